>>> sv/mpq_pkg.sv
// mpq_pkg: shared codes and default sizes for the min priority queue
// opcode and status codes, cell command codes and the cell control bundle
// no dependencies
package mpq_pkg;

  // default sizes for the top level parameters
  localparam int CAPACITY_DEFAULT = 64;
  localparam int ID_BITS_DEFAULT  = 16;
  localparam int KEY_BITS_DEFAULT = 32;

  // width of the result id field on the output channel
  localparam int OUT_ID_BITS = 16;

  // request opcodes
  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_CHANGE_KEY = 2'd1,
    OP_EXTRACT    = 2'd2,
    OP_NOP        = 2'd3
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // command broadcast to every cell of the chain
  typedef enum logic [4:0] {
    CMD_HOLD    = 5'b00001,
    CMD_MATCH   = 5'b00010,
    CMD_COMPARE = 5'b00100,
    CMD_UPDATE  = 5'b01000,
    CMD_EXTRACT = 5'b10000
  } cell_cmd_t;

  // control bundle from the sequencer to the cells
  typedef struct packed {
    cell_cmd_t cmd;
    logic      is_insert;
  } cell_ctl_t;

endpackage

>>> sv/mpq_cell.sv
// mpq_cell: one slot of the sorted entry chain
// holds one entry, trades entries with its two neighbors on update and takes the next neighbor's entry on extract
// depends on mpq_pkg
module mpq_cell #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEFAULT,
  parameter int ID_BITS  = mpq_pkg::ID_BITS_DEFAULT,
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEFAULT,
  parameter int INDEX    = 0,
  localparam int RB      = $clog2(CAPACITY),
  localparam int CB      = $clog2(CAPACITY + 1),
  localparam int REC_W   = 1 + ID_BITS + KEY_BITS + 2 * RB
) (
  input  logic                clk,
  input  logic                rst,
  input  mpq_pkg::cell_ctl_t  ctl,
  input  logic [ID_BITS-1:0]  req_id,
  input  logic [CB-1:0]       count,
  input  logic [REC_W-1:0]    bc_rec,
  input  logic [RB-1:0]       bc_pos,
  input  logic [REC_W-1:0]    head_rec,
  input  logic [REC_W-1:0]    prev_rec,
  input  logic                prev_lt,
  input  logic [REC_W-1:0]    next_rec,
  input  logic                next_lt,
  output logic [REC_W-1:0]    cur_rec,
  output logic [REC_W-1:0]    shift_rec,
  output logic                lt,
  output logic                hit,
  output logic                ymatch
);

  // entry: youngest of its id, id, key, age rank, count of older same-id entries
  typedef struct packed {
    logic                youngest;
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
    logic [RB-1:0]       rank;
    logic [RB-1:0]       dup;
  } entry_t;

  localparam logic [RB-1:0] IDX   = RB'(INDEX);
  localparam logic [CB-1:0] IDX_C = CB'(INDEX);

  entry_t cur;
  entry_t cur_next;
  entry_t prev_e;
  entry_t next_e;
  entry_t bc_e;
  entry_t head_e;
  entry_t own_upd;
  entry_t own_ext;
  logic   valid;

  assign prev_e = prev_rec;
  assign next_e = next_rec;
  assign bc_e   = bc_rec;
  assign head_e = head_rec;
  assign valid  = IDX_C < count;

  // entry as handed on during update: youngest mark moves to the new insert
  always_comb begin
    own_upd = cur;
    if (ymatch) begin
      own_upd.youngest = 1'b0;
    end
  end

  // entry as handed on during extract: close the age and duplicate ranks
  always_comb begin
    own_ext = cur;
    if (cur.rank > head_e.rank) begin
      own_ext.rank = cur.rank - RB'(1);
      if (cur.id == head_e.id) begin
        own_ext.dup = cur.dup - RB'(1);
      end
    end
    if (head_e.youngest && (head_e.dup != '0) && (cur.id == head_e.id) &&
        (cur.dup == head_e.dup - RB'(1))) begin
      own_ext.youngest = 1'b1;
    end
  end

  assign shift_rec = (ctl.cmd == mpq_pkg::CMD_EXTRACT) ? own_ext : own_upd;
  assign cur_rec   = cur;

  // next entry: on update move the request entry from its old slot to its sorted slot, on extract shift up
  always_comb begin
    cur_next = cur;
    case (ctl.cmd)
      mpq_pkg::CMD_UPDATE: begin
        if (hit) begin
          if (!prev_lt) begin
            cur_next = prev_e;
          end else if (next_lt) begin
            cur_next = next_e;
          end else begin
            cur_next = bc_e;
          end
        end else if (IDX < bc_pos) begin
          if (lt) begin
            cur_next = own_upd;
          end else if (prev_lt) begin
            cur_next = bc_e;
          end else begin
            cur_next = prev_e;
          end
        end else begin
          if (!lt) begin
            cur_next = own_upd;
          end else if (next_lt) begin
            cur_next = next_e;
          end else begin
            cur_next = bc_e;
          end
        end
      end
      mpq_pkg::CMD_EXTRACT: begin
        cur_next = next_e;
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // per-cell match and order flags
  always_ff @(posedge clk) begin
    if (rst) begin
      hit    <= 1'b0;
      ymatch <= 1'b0;
      lt     <= 1'b0;
    end else begin
      case (ctl.cmd)
        mpq_pkg::CMD_MATCH: begin
          if (ctl.is_insert) begin
            hit    <= IDX_C == count;
            ymatch <= valid && (cur.id == req_id) && cur.youngest;
          end else begin
            hit    <= valid && (cur.id == req_id) && (cur.dup == '0);
            ymatch <= 1'b0;
          end
        end
        mpq_pkg::CMD_COMPARE: begin
          lt <= valid && !hit &&
                ((cur.key < bc_e.key) || ((cur.key == bc_e.key) && (cur.rank < bc_e.rank)));
        end
        default: begin
          hit <= hit;
        end
      endcase
    end
  end

endmodule

>>> sv/min_priority_queue.sv
// min_priority_queue: top level with request sequencer, gather logic and cell chain
// depends on mpq_pkg and mpq_cell
//
// A bounded min-priority queue of (id, key) entries held in a chain of cells kept
// sorted by key, equal keys in insertion order, so the least entry always sits in
// the first cell. One request is worked on at a time. Extract and the unused opcode
// go from accept straight to the update step, as does an insert into a full queue;
// insert and change key pass through the steps match, gather, compare, update that
// locate the entry and then move it to its sorted slot in one shift of the chain.
// A new request is accepted while the previous result waits on the output register;
// a stalled output holds the request being worked on in its update step.
module min_priority_queue #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEFAULT,
  parameter int ID_BITS  = mpq_pkg::ID_BITS_DEFAULT,
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic [ID_BITS-1:0]              item_id,
  input  logic [KEY_BITS-1:0]             new_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [mpq_pkg::OUT_ID_BITS-1:0] result_id
);

  localparam int RB    = $clog2(CAPACITY);
  localparam int CB    = $clog2(CAPACITY + 1);
  localparam int REC_W = 1 + ID_BITS + KEY_BITS + 2 * RB;
  localparam int OB    = mpq_pkg::OUT_ID_BITS;

  typedef struct packed {
    logic                youngest;
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
    logic [RB-1:0]       rank;
    logic [RB-1:0]       dup;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_MATCH   = 5'b00010,
    S_GATHER  = 5'b00100,
    S_COMPARE = 5'b01000,
    S_UPDATE  = 5'b10000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [CB-1:0]        count;
  mpq_pkg::opcode_t     req_op;
  mpq_pkg::opcode_t     in_op;
  logic [ID_BITS-1:0]   req_id;
  logic [KEY_BITS-1:0]  req_key;
  entry_t               bc;
  entry_t               bc_next;
  logic [RB-1:0]        bc_pos;
  logic [RB-1:0]        pos_next;
  logic                 found;
  logic                 found_next;
  mpq_pkg::cell_ctl_t   ctl;
  mpq_pkg::status_t     status_next;
  logic [OB-1:0]        rid_next;
  logic [ID_BITS+OB-1:0] rid_ext;
  entry_t               head;
  logic                 full;
  logic                 fire;
  logic                 do_cells;
  logic                 has_entry;

  logic [REC_W-1:0]     cur_rec   [CAPACITY];
  logic [REC_W-1:0]     shift_rec [CAPACITY];
  logic [REC_W-1:0]     shift_pad [CAPACITY+2];
  logic [CAPACITY+1:0]  lt_pad;
  logic [CAPACITY-1:0]  lt_v;
  logic [CAPACITY-1:0]  hit_v;
  logic [CAPACITY-1:0]  ym_v;

  assign in_ready  = state == S_IDLE;
  assign in_op     = mpq_pkg::opcode_t'(opcode);
  assign head      = cur_rec[0];
  assign full      = count == CB'(CAPACITY);
  assign has_entry = count != '0;
  assign fire      = (state == S_UPDATE) && (!out_valid || out_ready);
  assign do_cells  = ((req_op == mpq_pkg::OP_INSERT) && !full) ||
                     ((req_op == mpq_pkg::OP_CHANGE_KEY) && found);

  // neighbor links with fixed ends: nothing before the first cell, empty after the last
  assign shift_pad[0]          = '0;
  assign shift_pad[CAPACITY+1] = '0;
  assign lt_pad[0]             = 1'b1;
  assign lt_pad[CAPACITY+1]    = 1'b0;

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign shift_pad[g+1] = shift_rec[g];
    assign lt_pad[g+1]    = lt_v[g];

    mpq_cell #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS),
      .KEY_BITS (KEY_BITS),
      .INDEX    (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .req_id    (req_id),
      .count     (count),
      .bc_rec    (bc),
      .bc_pos    (bc_pos),
      .head_rec  (cur_rec[0]),
      .prev_rec  (shift_pad[g]),
      .prev_lt   (lt_pad[g]),
      .next_rec  (shift_pad[g+2]),
      .next_lt   (lt_pad[g+2]),
      .cur_rec   (cur_rec[g]),
      .shift_rec (shift_rec[g]),
      .lt        (lt_v[g]),
      .hit       (hit_v[g]),
      .ymatch    (ym_v[g])
    );
  end

  // cell command for the current step
  always_comb begin
    ctl.is_insert = req_op == mpq_pkg::OP_INSERT;
    case (state)
      S_MATCH:   ctl.cmd = mpq_pkg::CMD_MATCH;
      S_COMPARE: ctl.cmd = mpq_pkg::CMD_COMPARE;
      S_UPDATE: begin
        if (fire && do_cells) begin
          ctl.cmd = mpq_pkg::CMD_UPDATE;
        end else if (fire && (req_op == mpq_pkg::OP_EXTRACT) && has_entry) begin
          ctl.cmd = mpq_pkg::CMD_EXTRACT;
        end else begin
          ctl.cmd = mpq_pkg::CMD_HOLD;
        end
      end
      default:   ctl.cmd = mpq_pkg::CMD_HOLD;
    endcase
  end

  // gather the flagged entry and slot, and build the entry to place
  always_comb begin
    logic [REC_W-1:0] sel_vec;
    logic [RB-1:0]    mdup;
    logic             mfound;
    entry_t           tmp;
    sel_vec  = '0;
    mdup     = '0;
    mfound   = 1'b0;
    pos_next = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tmp = cur_rec[i];
      if (hit_v[i]) begin
        sel_vec  = sel_vec | cur_rec[i];
        pos_next = pos_next | RB'(i);
      end
      if (ym_v[i]) begin
        mdup   = mdup | tmp.dup;
        mfound = 1'b1;
      end
    end
    found_next = |hit_v;
    if (req_op == mpq_pkg::OP_INSERT) begin
      bc_next.youngest = 1'b1;
      bc_next.id       = req_id;
      bc_next.key      = req_key;
      bc_next.rank     = count[RB-1:0];
      bc_next.dup      = mfound ? mdup + RB'(1) : '0;
    end else begin
      bc_next     = sel_vec;
      bc_next.key = req_key;
    end
  end

  // result of the request
  assign rid_ext = {{OB{1'b0}}, head.id};

  always_comb begin
    rid_next = '0;
    case (req_op)
      mpq_pkg::OP_INSERT: begin
        status_next = full ? mpq_pkg::ST_FULL : mpq_pkg::ST_OK;
      end
      mpq_pkg::OP_CHANGE_KEY: begin
        status_next = found ? mpq_pkg::ST_OK : mpq_pkg::ST_NOT_FOUND;
      end
      mpq_pkg::OP_EXTRACT: begin
        status_next = has_entry ? mpq_pkg::ST_OK : mpq_pkg::ST_EMPTY;
        if (has_entry) begin
          rid_next = rid_ext[OB-1:0];
        end
      end
      default: begin
        status_next = mpq_pkg::ST_OK;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (((in_op == mpq_pkg::OP_INSERT) && !full) ||
              (in_op == mpq_pkg::OP_CHANGE_KEY)) begin
            state_next = S_MATCH;
          end else begin
            state_next = S_UPDATE;
          end
        end
      end
      S_MATCH:   state_next = S_GATHER;
      S_GATHER:  state_next = S_COMPARE;
      S_COMPARE: state_next = S_UPDATE;
      S_UPDATE: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
        if ((req_op == mpq_pkg::OP_INSERT) && !full) begin
          count <= count + CB'(1);
        end else if ((req_op == mpq_pkg::OP_EXTRACT) && has_entry) begin
          count <= count - CB'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request, broadcast entry and result registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op  <= in_op;
      req_id  <= item_id;
      req_key <= new_key;
    end
    if (state == S_GATHER) begin
      bc     <= bc_next;
      bc_pos <= pos_next;
      found  <= found_next;
    end
    if (fire) begin
      status    <= status_next;
      result_id <= rid_next;
    end
  end

endmodule
